### rtl/hxu_pkg.sv
// Shared constants, types and helpers for the hex text to UTF-8 decoder.
package hxu_pkg;

    localparam int STORE_DEPTH = 4;
    localparam int COUNT_OVER  = 5;
    localparam int CNT_W       = 3;
    localparam int IDX_W       = 2;

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_LOW_X = 8'h78;
    localparam logic [7:0] CHAR_UP_X  = 8'h58;

    // U+FFFD in UTF-8
    localparam logic [7:0] REPL_BYTE0 = 8'hEF;
    localparam logic [7:0] REPL_BYTE1 = 8'hBF;
    localparam logic [7:0] REPL_BYTE2 = 8'hBD;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } hex_digit_t;

    typedef struct packed {
        logic       bad;
        logic [6:0] value;
    } symbol_t;

    function automatic hex_digit_t hex_value(input logic [7:0] c);
        hex_digit_t d;
        d.ok    = 1'b1;
        d.value = 4'd0;
        if (c >= 8'h30 && c <= 8'h39)
        begin
            d.value = 4'(c - 8'h30);
        end
        else if (c >= 8'h41 && c <= 8'h46)
        begin
            d.value = 4'(c - 8'h37);
        end
        else if (c >= 8'h61 && c <= 8'h66)
        begin
            d.value = 4'(c - 8'h57);
        end
        else
        begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

    function automatic logic is_x(input logic [7:0] c);
        return (c == CHAR_LOW_X) || (c == CHAR_UP_X);
    endfunction

endpackage

### rtl/hxu_decode.sv
// Token decode: prefix removal, hex digit check and range check of a stored token.
module hxu_decode
(
    input  logic [7:0]            store [hxu_pkg::STORE_DEPTH],
    input  logic [hxu_pkg::CNT_W-1:0] count,
    input  logic                  interior,
    output hxu_pkg::symbol_t      symbol
);

    logic [hxu_pkg::CNT_W-1:0] start;
    logic [hxu_pkg::CNT_W-1:0] remain;
    logic [hxu_pkg::IDX_W-1:0] idx0;
    logic [hxu_pkg::IDX_W-1:0] idx1;
    hxu_pkg::hex_digit_t       d0;
    hxu_pkg::hex_digit_t       d1;
    logic [7:0]                value8;
    logic                      bad;

    always_comb
    begin
        if (count >= 3'd2 && store[0] == hxu_pkg::CHAR_ZERO && hxu_pkg::is_x(store[1]))
        begin
            start = 3'd2;
        end
        else if (count >= 3'd1 && hxu_pkg::is_x(store[0]))
        begin
            start = 3'd1;
        end
        else
        begin
            start = 3'd0;
        end

        remain = count - start;
        idx0   = start[hxu_pkg::IDX_W-1:0];
        idx1   = idx0 + 2'd1;
        d0     = hxu_pkg::hex_value(store[idx0]);
        d1     = hxu_pkg::hex_value(store[idx1]);

        if (remain == 3'd2)
        begin
            value8 = {d0.value, d1.value};
        end
        else
        begin
            value8 = {4'd0, d0.value};
        end

        bad = interior
            || (count > 3'(hxu_pkg::STORE_DEPTH))
            || (remain == 3'd0)
            || (remain > 3'd2)
            || !d0.ok
            || ((remain == 3'd2) && !d1.ok)
            || value8[7];

        symbol.bad   = bad;
        symbol.value = value8[6:0];
    end

endmodule

### rtl/hex_text_to_utf8_decoder.sv
// Top level: hex text tokeniser with UTF-8 byte output.
// Takes one text character per cycle while no closing request waits. A space or
// a request with tlast set closes the current token; a non-empty token yields
// one symbol, either the decoded byte or U+FFFD as EF BF BD. One symbol is held
// in the output register; a closing request that yields a symbol waits while
// the previous symbol is still being sent, all other requests are taken at once.
// A symbol's first byte appears in the cycle after its closing request is taken.
module hex_text_to_utf8_decoder
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] text_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic       m_tlast    // symbol_end
);

    logic [7:0]                store_reg [hxu_pkg::STORE_DEPTH];
    logic [hxu_pkg::CNT_W-1:0] count_reg;
    logic [hxu_pkg::CNT_W-1:0] count_next;
    logic                      trail_reg;
    logic                      trail_next;
    logic                      interior_reg;
    logic                      interior_next;

    logic                      pend_valid_reg;
    logic                      pend_valid_next;
    logic [hxu_pkg::IDX_W-1:0] pend_idx_reg;
    logic [hxu_pkg::IDX_W-1:0] pend_idx_next;
    hxu_pkg::symbol_t          pend_sym_reg;

    hxu_pkg::symbol_t          dec_sym;
    logic                      is_close;
    logic                      is_strip;
    logic                      emits;
    logic                      accept;
    logic                      out_hs;
    logic                      store_we;

    hxu_decode u_decode
    (
        .store    (store_reg),
        .count    (count_reg),
        .interior (interior_reg),
        .symbol   (dec_sym)
    );

    assign is_close = s_tlast || (s_tdata == hxu_pkg::CHAR_SPACE);
    assign is_strip = (s_tdata >= hxu_pkg::CHAR_TAB) && (s_tdata <= hxu_pkg::CHAR_CR);
    assign emits    = is_close && (count_reg != 3'd0);
    assign s_tready = !pend_valid_reg || !emits;
    assign accept   = s_tvalid && s_tready;
    assign out_hs   = m_tvalid && m_tready;
    assign store_we = accept && !is_close && !is_strip
                      && (count_reg < 3'(hxu_pkg::STORE_DEPTH));

    always_comb
    begin
        count_next    = count_reg;
        trail_next    = trail_reg;
        interior_next = interior_reg;
        if (accept)
        begin
            if (is_close)
            begin
                count_next    = 3'd0;
                trail_next    = 1'b0;
                interior_next = 1'b0;
            end
            else if (is_strip)
            begin
                if (count_reg != 3'd0)
                begin
                    trail_next = 1'b1;
                end
            end
            else
            begin
                if (trail_reg)
                begin
                    interior_next = 1'b1;
                    trail_next    = 1'b0;
                end
                if (count_reg < 3'(hxu_pkg::COUNT_OVER))
                begin
                    count_next = count_reg + 3'd1;
                end
            end
        end
    end

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_idx_next   = pend_idx_reg;
        if (out_hs)
        begin
            if (m_tlast)
            begin
                pend_valid_next = 1'b0;
            end
            else
            begin
                pend_idx_next = pend_idx_reg + 2'd1;
            end
        end
        if (accept && emits)
        begin
            pend_valid_next = 1'b1;
            pend_idx_next   = 2'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg      <= '0;
            trail_reg      <= 1'b0;
            interior_reg   <= 1'b0;
            pend_valid_reg <= 1'b0;
            pend_idx_reg   <= '0;
        end
        else
        begin
            count_reg      <= count_next;
            trail_reg      <= trail_next;
            interior_reg   <= interior_next;
            pend_valid_reg <= pend_valid_next;
            pend_idx_reg   <= pend_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            store_reg[count_reg[hxu_pkg::IDX_W-1:0]] <= s_tdata;
        end
        if (accept && emits)
        begin
            pend_sym_reg <= dec_sym;
        end
    end

    always_comb
    begin
        m_tvalid = pend_valid_reg;
        if (pend_sym_reg.bad)
        begin
            case (pend_idx_reg)
                2'd0:    m_tdata = hxu_pkg::REPL_BYTE0;
                2'd1:    m_tdata = hxu_pkg::REPL_BYTE1;
                default: m_tdata = hxu_pkg::REPL_BYTE2;
            endcase
            m_tlast = (pend_idx_reg == 2'd2);
        end
        else
        begin
            m_tdata = {1'b0, pend_sym_reg.value};
            m_tlast = 1'b1;
        end
    end

endmodule

### rtl/hxu_checker.sv
// Port-level checker for the hex text to UTF-8 decoder, with its bind.
module hxu_checker
(
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic [7:0] s_tdata,
    input logic       s_tlast,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output request changed while stalled");

    a_mid_byte: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tlast |-> (m_tdata == hxu_pkg::REPL_BYTE0)
                                 || (m_tdata == hxu_pkg::REPL_BYTE1))
        else $error("non-final byte is not a U+FFFD lead byte");

    a_high_final: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tlast && m_tdata[7] |-> m_tdata == hxu_pkg::REPL_BYTE2)
        else $error("final byte above 127 is not the U+FFFD tail");

    a_repl_seq: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tready && (m_tdata == hxu_pkg::REPL_BYTE0)
        |=> m_tvalid && (m_tdata == hxu_pkg::REPL_BYTE1) && !m_tlast)
        else $error("U+FFFD sequence broken after first byte");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid && (s_tlast || (s_tdata == hxu_pkg::CHAR_SPACE)))
        else $error("input stalled without a pending symbol");

endmodule

bind hex_text_to_utf8_decoder hxu_checker u_hxu_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
